@@ src/i2cram_pkg.sv @@
// Shared types, codes and sequencing functions for the I2C register access master.
// No dependencies; imported by the core, the output buffer and the top level.
package i2cram_pkg;

    localparam int unsigned PHASE_W = 10;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned BIT_W   = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        K_END,
        K_START,
        K_SEND_AW,
        K_SEND_REG,
        K_SEND_DATA,
        K_SEND_AR,
        K_RECV,
        K_STOP
    } t_kind;

    typedef struct packed {
        logic       rejected;
        logic       nack_seen;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    function automatic t_kind prog_kind(input logic [STEP_W-1:0] step, input logic is_read);
        t_kind k;
        k = K_END;
        if (!is_read) begin
            unique case (step)
                4'd1:    k = K_START;
                4'd2:    k = K_SEND_AW;
                4'd3:    k = K_SEND_REG;
                4'd4:    k = K_SEND_DATA;
                4'd5:    k = K_STOP;
                default: k = K_END;
            endcase
        end else begin
            unique case (step)
                4'd1:    k = K_START;
                4'd2:    k = K_SEND_AW;
                4'd3:    k = K_SEND_REG;
                4'd4:    k = K_START;
                4'd5:    k = K_SEND_AR;
                4'd6:    k = K_RECV;
                4'd7:    k = K_STOP;
                default: k = K_END;
            endcase
        end
        return k;
    endfunction

    function automatic logic is_send(input t_kind k);
        return (k == K_SEND_AW) || (k == K_SEND_REG) || (k == K_SEND_DATA) || (k == K_SEND_AR);
    endfunction

    // Returns {scl, sda} after applying the pin phase.
    function automatic logic [1:0] drive_phase(
        input t_kind            k,
        input logic [1:0]       sub,
        input logic [BIT_W-1:0] bidx,
        input logic [7:0]       shift,
        input logic [1:0]       cur
    );
        logic scl;
        logic sda;
        scl = cur[1];
        sda = cur[0];
        if (k == K_START) begin
            case (sub)
                2'd0:    sda = 1'b1;
                2'd1:    scl = 1'b1;
                2'd2:    sda = 1'b0;
                default: scl = 1'b0;
            endcase
        end else if (is_send(k)) begin
            case (sub)
                2'd0:    sda = (bidx < BITS_PER_BYTE) ? shift[3'd7 - bidx[2:0]] : 1'b1;
                2'd1:    scl = 1'b1;
                default: scl = 1'b0;
            endcase
        end else if (k == K_RECV) begin
            case (sub)
                2'd0:    sda = 1'b1;
                2'd1:    scl = 1'b1;
                default: scl = 1'b0;
            endcase
        end else if (k == K_STOP) begin
            case (sub)
                2'd0:    sda = 1'b0;
                2'd1:    scl = 1'b1;
                default: sda = 1'b1;
            endcase
        end
        return {scl, sda};
    endfunction

endpackage

@@ src/i2cram_core.sv @@
// Bus sequencer: holds the transaction state and advances it one tick per transfer.
// Depends on i2cram_pkg for phase kinds, op codes and the result struct.
module i2cram_core
    import i2cram_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_device_addr,
    input  logic [7:0]         i_reg_addr,
    input  logic [7:0]         i_write_data,
    input  logic               i_sda_in,
    input  logic               i_cfg_we,
    input  logic [PHASE_W-1:0] i_cfg_wdata,
    output t_result            o_result
);

    logic [PHASE_W-1:0] r_phase_ticks;
    logic [STEP_W-1:0]  r_step,   n_step;
    logic [1:0]         r_sub,    n_sub;
    logic [BIT_W-1:0]   r_bit,    n_bit;
    logic [PHASE_W-1:0] r_cnt,    n_cnt;
    logic [7:0]         r_shift,  n_shift;
    logic               r_is_read, n_is_read;
    logic [23:0]        r_addrs,  n_addrs;
    logic               r_nack,   n_nack;
    logic [7:0]         r_result, n_result;
    logic [1:0]         r_drive,  n_drive;

    logic [PHASE_W-1:0] limit;
    t_kind              kind;
    t_kind              kind_next;
    logic [2:0]         sub_inc;
    logic [2:0]         sub_count;
    logic               seg_next;
    logic               done;
    logic               rej;
    logic               is_cmd;

    assign limit  = (r_phase_ticks == '0) ? PHASE_W'(1) : r_phase_ticks;
    assign is_cmd = (i_op == OP_WRITE) || (i_op == OP_READ);
    assign kind   = prog_kind(r_step, r_is_read);

    always_comb begin
        n_step    = r_step;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_is_read = r_is_read;
        n_addrs   = r_addrs;
        n_nack    = r_nack;
        n_result  = r_result;
        n_drive   = r_drive;
        done      = 1'b0;
        rej       = 1'b0;
        seg_next  = 1'b0;
        kind_next = kind;
        sub_inc   = {1'b0, r_sub} + 3'd1;
        sub_count = (kind == K_START) ? 3'd4 : 3'd3;
        if (r_step != '0) begin
            rej = is_cmd;
            if (r_cnt >= limit) begin
                n_cnt = PHASE_W'(1);
                if (is_send(kind) && (r_bit == BITS_PER_BYTE) && (r_sub == 2'd1)) begin
                    n_nack = r_nack | i_sda_in;
                end
                if ((kind == K_RECV) && (r_bit < BITS_PER_BYTE) && (r_sub == 2'd1)) begin
                    n_shift = {r_shift[6:0], i_sda_in};
                    if (r_bit == 4'd7) begin
                        n_result = n_shift;
                    end
                end
                if (sub_inc >= sub_count) begin
                    n_sub    = 2'd0;
                    seg_next = 1'b1;
                    if (is_send(kind) || (kind == K_RECV)) begin
                        n_bit = r_bit + 4'd1;
                        if (n_bit <= BITS_PER_BYTE) begin
                            seg_next = 1'b0;
                            if ((kind == K_RECV) && (n_bit < BITS_PER_BYTE)) begin
                                n_sub = 2'd1;
                            end
                        end
                    end
                    if (seg_next) begin
                        n_step    = r_step + 4'd1;
                        kind_next = prog_kind(n_step, r_is_read);
                        n_sub     = 2'd0;
                        n_bit     = '0;
                        case (kind_next)
                            K_SEND_AW:   n_shift = r_addrs[23:16] & 8'hFE;
                            K_SEND_REG:  n_shift = r_addrs[15:8];
                            K_SEND_DATA: n_shift = r_addrs[7:0];
                            K_SEND_AR:   n_shift = r_addrs[23:16] | 8'h01;
                            K_RECV:      n_shift = 8'h00;
                            default:     n_shift = n_shift;
                        endcase
                        if (kind_next == K_END) begin
                            n_step = '0;
                            done   = 1'b1;
                            n_cnt  = '0;
                        end
                    end
                end else begin
                    n_sub = sub_inc[1:0];
                end
                n_drive = drive_phase(kind_next, n_sub, n_bit, n_shift, r_drive);
            end else begin
                n_cnt = r_cnt + PHASE_W'(1);
            end
        end else if (is_cmd) begin
            n_is_read = (i_op == OP_READ);
            n_addrs   = {i_device_addr, i_reg_addr, i_write_data};
            n_nack    = 1'b0;
            n_step    = 4'd1;
            n_sub     = 2'd0;
            n_bit     = '0;
            n_cnt     = PHASE_W'(1);
            n_drive   = drive_phase(K_START, 2'd0, '0, r_shift, r_drive);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_W'(1);
            r_step        <= '0;
            r_sub         <= '0;
            r_bit         <= '0;
            r_cnt         <= '0;
            r_shift       <= '0;
            r_is_read     <= 1'b0;
            r_addrs       <= '0;
            r_nack        <= 1'b0;
            r_result      <= '0;
            r_drive       <= 2'b11;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (i_step) begin
                r_step    <= n_step;
                r_sub     <= n_sub;
                r_bit     <= n_bit;
                r_cnt     <= n_cnt;
                r_shift   <= n_shift;
                r_is_read <= n_is_read;
                r_addrs   <= n_addrs;
                r_nack    <= n_nack;
                r_result  <= n_result;
                r_drive   <= n_drive;
            end
        end
    end

    always_comb begin
        o_result.scl_level = n_drive[1];
        o_result.sda_level = n_drive[0];
        o_result.busy_res  = (n_step != '0);
        o_result.done_res  = done;
        o_result.read_byte = n_result;
        o_result.nack_seen = n_nack;
        o_result.rejected  = rej;
    end

endmodule

@@ src/i2cram_skid.sv @@
// Two-entry output buffer between the sequencer and the result stream.
// Depends on i2cram_pkg for the result struct.
module i2cram_skid
    import i2cram_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= i_data;
            end
        end else if (i_ready) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/i2c_register_access_master_unit.sv @@
// Each result is registered in the output buffer before it reaches the master side.
// Throughput: one tick per cycle; the input side stalls only while both output
// buffer entries are full.
// Reset (synchronous, active low): sequencer idle, both lines released, phase
// length 1, read byte and ack status cleared, output buffer empty.
// Depends on i2cram_pkg, i2cram_core and i2cram_skid.
module i2c_register_access_master_unit
    import i2cram_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // device_addr, reg_addr, write_data, sda_in, zero pad
    input  logic [1:0]         s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // scl_level, sda_level, busy_res, done_res,
                                          // read_byte, nack_seen, rejected, zero pad
    input  logic               i_cfg_we,
    input  logic [PHASE_W-1:0] i_cfg_wdata
);

    logic    step;
    t_result core_result;
    t_result out_result;

    assign step = s_tvalid && s_tready;

    i2cram_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_op          (s_tuser),
        .i_device_addr (s_tdata[7:0]),
        .i_reg_addr    (s_tdata[15:8]),
        .i_write_data  (s_tdata[23:16]),
        .i_sda_in      (s_tdata[24]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_result      (core_result)
    );

    i2cram_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (core_result),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (out_result)
    );

    assign m_tdata = {{(16 - RESULT_W){1'b0}}, out_result};

endmodule

@@ src/i2cram_checker.sv @@
// Port-level checks for the I2C register access master, bound to the top level.
// Depends on i2c_register_access_master_unit's port list only.
module i2cram_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done reported while busy");

    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[1])
        else $error("lines not released at stop");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind i2c_register_access_master_unit i2cram_checker u_chk (.*);

@@ tb/i2c_register_access_master_unit_tb.sv @@
// Self-checking testbench for i2c_register_access_master_unit: drives bus ticks and
// commands on the input stream, predicts every pin/status result and compares them.
// Depends on i2cram_pkg and the RTL of the unit; needs no files or arguments.
module i2c_register_access_master_unit_tb;
    import i2cram_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned MAX_REPORTS = 40;

    class pin_trace_scoreboard;
        t_kind wr_prog[8] = '{K_START, K_SEND_AW, K_SEND_REG, K_SEND_DATA,
                              K_STOP, K_END, K_END, K_END};
        t_kind rd_prog[8] = '{K_START, K_SEND_AW, K_SEND_REG, K_START,
                              K_SEND_AR, K_RECV, K_STOP, K_END};
        logic [PHASE_W-1:0] phase_len;
        logic [3:0]         step;
        logic [2:0]         sub;
        logic [BIT_W-1:0]   bidx;
        logic [PHASE_W-1:0] cnt;
        logic [7:0]         shreg;
        logic               rd;
        logic [23:0]        addrs;
        logic               nack;
        logic [7:0]         rx_byte;
        logic               scl_q;
        logic               sda_q;
        t_result            pin_levels_due[$];
        int                 errors;

        function new();
            phase_len = 10'd1;
            step      = '0;
            sub       = '0;
            bidx      = '0;
            cnt       = '0;
            shreg     = '0;
            rd        = 1'b0;
            addrs     = '0;
            nack      = 1'b0;
            rx_byte   = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            errors    = 0;
        endfunction

        function t_kind kind();
            if (step < 4'd1 || step > 4'd8)
                return K_END;
            return rd ? rd_prog[int'(step) - 1] : wr_prog[int'(step) - 1];
        endfunction

        function bit sending(t_kind k);
            return (k == K_SEND_AW) || (k == K_SEND_REG) || (k == K_SEND_DATA)
                || (k == K_SEND_AR);
        endfunction

        function void drive();
            t_kind k;
            k = kind();
            if (k == K_START) begin
                case (sub)
                    3'd0:    sda_q = 1'b1;
                    3'd1:    scl_q = 1'b1;
                    3'd2:    sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end else if (sending(k)) begin
                if (sub == 3'd0)
                    sda_q = (bidx < 4'd8) ? shreg[3'd7 - bidx[2:0]] : 1'b1;
                else if (sub == 3'd1)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end else if (k == K_RECV) begin
                if (sub == 3'd0)
                    sda_q = 1'b1;
                else if (sub == 3'd1)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end else if (k == K_STOP) begin
                if (sub == 3'd0)
                    sda_q = 1'b0;
                else if (sub == 3'd1)
                    scl_q = 1'b1;
                else
                    sda_q = 1'b1;
            end
        endfunction

        function void load();
            t_kind k;
            k = kind();
            sub  = '0;
            bidx = '0;
            case (k)
                K_SEND_AW:   shreg = addrs[23:16] & 8'hFE;
                K_SEND_REG:  shreg = addrs[15:8];
                K_SEND_DATA: shreg = addrs[7:0];
                K_SEND_AR:   shreg = addrs[23:16] | 8'h01;
                K_RECV:      shreg = '0;
                default: ;
            endcase
        endfunction

        // advance one pin phase; returns 1 when the stop condition has completed
        function bit leave(logic s);
            t_kind      k;
            logic [2:0] count;
            k = kind();
            count = (k == K_START) ? 3'd4 : 3'd3;
            if (sending(k) && bidx == 4'd8 && sub == 3'd1)
                nack = nack | s;
            if (k == K_RECV && bidx < 4'd8 && sub == 3'd1) begin
                shreg = {shreg[6:0], s};
                if (bidx == 4'd7)
                    rx_byte = shreg;
            end
            sub = sub + 3'd1;
            if (sub >= count) begin
                sub = '0;
                if (sending(k) || k == K_RECV) begin
                    bidx = bidx + 4'd1;
                    if (bidx <= 4'd8) begin
                        if (k == K_RECV && bidx < 4'd8)
                            sub = 3'd1;
                        drive();
                        return 1'b0;
                    end
                end
                step = step + 4'd1;
                load();
                if (kind() == K_END) begin
                    step = '0;
                    return 1'b1;
                end
            end
            drive();
            return 1'b0;
        endfunction

        function int unsigned limit();
            return (phase_len == '0) ? 1 : int'(phase_len);
        endfunction

        function bit busy();
            return step != '0;
        endfunction

        function bit ends_next();
            return busy() && kind() == K_STOP && sub == 3'd2 && cnt >= limit();
        endfunction

        function int pending();
            return pin_levels_due.size();
        endfunction

        function void note_transfer(logic [1:0] op, logic [7:0] dev_a, logic [7:0] reg_a,
                                    logic [7:0] wr_d, logic sda);
            t_result r;
            logic    fin;
            logic    rej;
            fin = 1'b0;
            rej = 1'b0;
            if (busy()) begin
                if (op == OP_WRITE || op == OP_READ)
                    rej = 1'b1;
                if (cnt >= limit()) begin
                    cnt = 10'd1;
                    if (leave(sda)) begin
                        fin = 1'b1;
                        cnt = '0;
                    end
                end else begin
                    cnt = cnt + 10'd1;
                end
            end else if (op == OP_WRITE || op == OP_READ) begin
                rd    = (op == OP_READ);
                addrs = {dev_a, reg_a, wr_d};
                nack  = 1'b0;
                step  = 4'd1;
                load();
                drive();
                cnt = 10'd1;
            end
            r.scl_level = scl_q;
            r.sda_level = sda_q;
            r.busy_res  = busy();
            r.done_res  = fin;
            r.read_byte = rx_byte;
            r.nack_seen = nack;
            r.rejected  = rej;
            pin_levels_due.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void compare_result(logic [15:0] raw);
            t_result got;
            t_result want;
            got = t_result'(raw[RESULT_W-1:0]);
            if (pin_levels_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual %h", $time, raw);
                return;
            end
            want = pin_levels_due.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
            check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
            check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
            check_field("rejected", 8'(want.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;      // device_addr, reg_addr, write_data, sda_in, zero pad
    logic [1:0]         s_tuser = OP_TICK; // op
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;           // scl_level, sda_level, busy_res, done_res,
                                           // read_byte, nack_seen, rejected, zero pad
    logic               i_cfg_we = 1'b0;
    logic [PHASE_W-1:0] i_cfg_wdata = '0;

    pin_trace_scoreboard pin_trace = new();
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          rx_hold_req = 0;
    int          sda_mode = 0;
    int unsigned cycles = 0;

    i2c_register_access_master_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [1:0] pick_cmd();
        return ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
    endfunction

    function automatic logic pick_sda();
        case (sda_mode)
            1:       return 1'b0;
            2:       return 1'b1;
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] dev_a,
                             input logic [7:0] reg_a, input logic [7:0] wr_d,
                             input logic sda);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, sda, wr_d, reg_a, dev_a};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pin_trace.note_transfer(op, dev_a, reg_a, wr_d, sda);
    endtask

    task automatic busy_item();
        logic [1:0] op;
        int         r;
        r = $urandom_range(0, 99);
        if (pin_trace.ends_next() && r < 40)
            op = pick_cmd();
        else if (r < 4)
            op = pick_cmd();
        else if (r < 8)
            op = OP_UNUSED;
        else
            op = OP_TICK;
        send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), pick_sda());
    endtask

    task automatic idle_item();
        logic [1:0] op;
        int         r;
        int         m;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            op = pick_cmd();
            m = $urandom_range(0, 3);
            sda_mode = (m < 2) ? 0 : m - 1;
        end else if (r < 72) begin
            op = OP_UNUSED;
        end else begin
            op = OP_TICK;
        end
        send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), pick_sda());
    endtask

    task automatic finish_transfer();
        while (pin_trace.busy()) busy_item();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pin_trace.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_phase_len(input logic [PHASE_W-1:0] value);
        finish_transfer();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pin_trace.phase_len = value;
    endtask

    // result side: random holds, plus a long hold on request
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (rx_hold_req != 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            pin_trace.compare_result(m_tdata);
        end
    end

    initial begin
        logic [PHASE_W-1:0] lens[4];
        lens[0] = 10'd2;
        lens[1] = 10'd0;
        lens[2] = 10'd1;
        lens[3] = 10'($urandom_range(3, 6));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_phase_len(10'd1);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);

        // write with every ack high, commands while busy and on the finishing tick
        sda_mode = 2;
        send_item(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1);
        send_item(OP_UNUSED, 8'h12, 8'h34, 8'h56, 1'b1);
        send_item(OP_READ, 8'h00, 8'hFF, 8'h00, 1'b1);
        send_item(OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        while (!pin_trace.ends_next()) send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(OP_READ, 8'h5A, 8'hA5, 8'h3C, 1'b1);

        // read that receives all zeros
        sda_mode = 1;
        send_item(OP_READ, 8'h00, 8'hFF, 8'h00, 1'b0);
        finish_transfer();

        // zero phase length acts as one; the last length is left unfinished
        sda_mode = 0;
        for (int p = 0; p < 4; p++) begin
            set_phase_len(lens[p]);
            tx_idle = (p != 2);
            rx_idle = (p != 2);
            for (int n = 0; n < 40; n++) begin
                if (p == 0 && n == 20)
                    rx_hold_req = 300;
                if (p == 1 && n == 20)
                    wait_drained();
                if (pin_trace.busy())
                    busy_item();
                else
                    idle_item();
            end
        end

        s_tvalid <= 1'b0;
        while (pin_trace.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pin_trace.errors == 0 && pin_trace.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
src/i2cram_pkg.sv
src/i2cram_core.sv
src/i2cram_skid.sv
src/i2c_register_access_master_unit.sv
src/i2cram_checker.sv
tb/i2c_register_access_master_unit_tb.sv
